>>> rtl/csps_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the clock-sync ping scanner: sizing constants,
// payload structs, result codes and the target-walk helper functions.
// No dependencies; rtl/clock_sync_ping_scanner_core.sv imports this package.
package csps_pkg;

    localparam int GRID_WIDTH   = 8;
    localparam int GRID_HEIGHT  = 8;
    localparam int CORES        = 18;
    localparam int DIM_ORDERS   = 6;
    localparam int PING_BIT_POS = 31;

    localparam int TABLE_SIZE = GRID_WIDTH * GRID_HEIGHT * (CORES + 1);
    localparam int ADDR_W     = $clog2(TABLE_SIZE);

    localparam int X_W     = 3;
    localparam int Y_W     = 3;
    localparam int CORE_W  = 5;
    localparam int ORDER_W = 3;
    localparam int CNT_W   = 16;
    localparam int DRIFT_W = 31;
    localparam int TIME_W  = 32;

    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [DRIFT_W-1:0] DRIFT_MAX = '1;

    // Input item kinds.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Result item kinds.
    localparam logic [1:0] OUT_PING   = 2'd0;
    localparam logic [1:0] OUT_CORR   = 2'd1;
    localparam logic [1:0] OUT_REPORT = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] remote_stamp;
        logic [TIME_W-1:0] now;
    } csps_in_t;

    typedef struct packed {
        logic [1:0]         out_kind;
        logic [X_W-1:0]     dest_x;
        logic [Y_W-1:0]     dest_y;
        logic [CORE_W-1:0]  dest_core;
        logic [ORDER_W-1:0] route_order;
        logic [TIME_W-1:0]  payload;
        logic [CNT_W-1:0]   responses;
        logic [CNT_W-1:0]   missing;
        logic [DRIFT_W-1:0] drift_total;
        logic               last;
    } csps_out_t;

    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [CORE_W-1:0] core;
    } csps_pos_t;

    typedef struct packed {
        csps_pos_t pos;
        logic      wrap;
    } csps_step_t;

    localparam csps_pos_t START_POS = '{x: '0, y: '0, core: CORE_W'(1)};

    // One step of the scan: x fastest, then y, then core; wrap flags a full pass.
    function automatic csps_step_t csps_advance(csps_pos_t p);
        csps_step_t r;
        r.pos  = p;
        r.wrap = 1'b0;
        if (p.x >= X_W'(GRID_WIDTH - 1)) begin
            r.pos.x = '0;
            if (p.y >= Y_W'(GRID_HEIGHT - 1)) begin
                r.pos.y = '0;
                if (p.core >= CORE_W'(CORES)) begin
                    r.pos.core = CORE_W'(1);
                    r.wrap     = 1'b1;
                end else begin
                    r.pos.core = p.core + 1'b1;
                end
            end else begin
                r.pos.y = p.y + 1'b1;
            end
        end else begin
            r.pos.x = p.x + 1'b1;
        end
        return r;
    endfunction

    // Next target to ping, stepping over the master's own position.
    function automatic csps_step_t csps_next_target(csps_pos_t p);
        csps_step_t s1;
        csps_step_t s2;
        csps_step_t r;
        s1 = csps_advance(p);
        s2 = csps_advance(s1.pos);
        r  = s1;
        if (s1.pos == START_POS) begin
            r.pos  = s2.pos;
            r.wrap = s1.wrap | s2.wrap;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] csps_addr(csps_pos_t p);
        int idx;
        idx = (int'(p.x) * GRID_HEIGHT + int'(p.y)) * (CORES + 1) + int'(p.core);
        return ADDR_W'(idx);
    endfunction

endpackage

>>> rtl/csps_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// A read of the address being written in the same cycle returns the old data.
// No dependencies.
module csps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/clock_sync_ping_scanner_core.sv
`timescale 1ns / 1ps
// Top level of the clock-sync ping scanner: scan position, reply bookkeeping,
// routing-order table and result queue. Depends on csps_pkg and csps_ram.
//
// After reset the routing-order table (TABLE_SIZE = 1216 entries) is cleared
// one entry per cycle, so s_ready stays low until the clearing pass is done.
// From then on one transaction is taken per cycle while the output queue has
// room: it is latched in the input stage together with the table read for the
// target it will ping, and its results then enter a two-entry output queue
// once there is room for them. A tick that completes a full scan produces a
// report and a ping, and the single output port then sets the pace for that
// item; every other item produces a single result.
module clock_sync_ping_scanner_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  csps_pkg::csps_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output csps_pkg::csps_out_t  m_data
);
    import csps_pkg::*;

    // Table clearing pass.
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // Look-ahead scan position: where the last accepted tick will ping.
    csps_pos_t la_pos_reg;

    // Input stage.
    logic              a_valid_reg;
    csps_in_t          a_data_reg;
    csps_step_t        a_step_reg;
    logic [ADDR_W-1:0] a_rd_addr_reg;
    logic              fwd_hit_reg;
    logic [ORDER_W-1:0] fwd_data_reg;

    // Scanner state.
    csps_pos_t          cur_pos_reg,     cur_pos_next;
    logic [ORDER_W-1:0] sent_order_reg,  sent_order_next;
    logic [TIME_W-1:0]  send_stamp_reg,  send_stamp_next;
    logic [TIME_W-1:0]  error_value_reg, error_value_next;
    logic               reply_seen_reg,  reply_seen_next;
    logic [CNT_W-1:0]   reply_count_reg, reply_count_next;
    logic [CNT_W-1:0]   miss_count_reg,  miss_count_next;
    logic [DRIFT_W-1:0] drift_sum_reg,   drift_sum_next;

    // Output queue.
    csps_out_t  q_reg [2];
    csps_out_t  q0_next, q1_next;
    logic [1:0] q_cnt_reg, q_cnt_next;

    logic               accept;
    logic               pop;
    logic               a_is_tick;
    logic [1:0]         a_need;
    logic [1:0]         q_free;
    logic               a_fire;
    csps_step_t         la_step;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ORDER_W-1:0] ram_rd_data;
    logic [ORDER_W:0]   ord_plus;
    logic [ORDER_W-1:0] ord_inc;
    logic               tbl_wr_run;
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [ORDER_W-1:0] ram_wr_data;
    logic [ORDER_W-1:0] ping_order;
    logic [TIME_W-1:0]  err_mag;
    logic [TIME_W:0]    drift_sum_wide;
    logic [CNT_W-1:0]   reply_count_upd;
    logic [CNT_W-1:0]   miss_count_upd;
    logic [DRIFT_W-1:0] drift_sum_upd;
    logic [TIME_W-1:0]  latency;
    logic [TIME_W-1:0]  reply_error;
    logic [TIME_W-1:0]  ping_bit;
    csps_out_t          res_ping, res_report, res_corr;
    csps_out_t          res0, res1;

    assign ping_bit = TIME_W'(1) << PING_BIT_POS;

    // ---------------------------------------------------------------- handshake
    assign pop       = m_valid && m_ready;
    assign a_is_tick = (a_data_reg.kind == KIND_TICK);
    assign a_need    = (a_is_tick && a_step_reg.wrap) ? 2'd2 : 2'd1;
    assign q_free    = (2'd2 - q_cnt_reg) + {1'b0, pop};
    assign a_fire    = a_valid_reg && (a_need <= q_free);
    assign s_ready   = !clr_active_reg && (!a_valid_reg || a_fire);
    assign accept    = s_valid && s_ready;

    // ---------------------------------------------------------------- table
    assign la_step  = csps_next_target(la_pos_reg);
    assign rd_addr  = csps_addr(la_step.pos);
    assign cur_addr = csps_addr(cur_pos_reg);

    // The entry of the current target always equals sent_order, since only a
    // tick on that target writes it, so the increment needs no table read.
    assign ord_plus   = {1'b0, sent_order_reg} + 1'b1;
    assign ord_inc    = (ord_plus >= (ORDER_W + 1)'(DIM_ORDERS)) ? '0
                                                                : ord_plus[ORDER_W-1:0];
    assign tbl_wr_run = a_fire && a_is_tick && !reply_seen_reg;

    assign ram_wr_en   = clr_active_reg || tbl_wr_run;
    assign ram_wr_addr = clr_active_reg ? clr_addr_reg : cur_addr;
    assign ram_wr_data = clr_active_reg ? '0 : ord_inc;

    csps_ram #(
        .WIDTH (ORDER_W),
        .DEPTH (TABLE_SIZE)
    ) u_order_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // The ping target equals the target being booked only when the scan has
    // a single position; a write on the read's own edge is forwarded too.
    always_comb begin
        if (!reply_seen_reg && (cur_addr == a_rd_addr_reg)) begin
            ping_order = ord_inc;
        end else if (fwd_hit_reg) begin
            ping_order = fwd_data_reg;
        end else begin
            ping_order = ram_rd_data;
        end
    end

    // ---------------------------------------------------------------- datapath
    assign err_mag        = error_value_reg[TIME_W-1] ? (~error_value_reg + 1'b1)
                                                      : error_value_reg;
    assign drift_sum_wide = (TIME_W + 1)'(drift_sum_reg) + (TIME_W + 1)'(err_mag);

    always_comb begin
        reply_count_upd = reply_count_reg;
        miss_count_upd  = miss_count_reg;
        drift_sum_upd   = drift_sum_reg;
        if (!reply_seen_reg) begin
            if (miss_count_reg != CNT_MAX) begin
                miss_count_upd = miss_count_reg + 1'b1;
            end
        end else begin
            if (reply_count_reg != CNT_MAX) begin
                reply_count_upd = reply_count_reg + 1'b1;
            end
            if (drift_sum_wide > (TIME_W + 1)'(DRIFT_MAX)) begin
                drift_sum_upd = DRIFT_MAX;
            end else begin
                drift_sum_upd = drift_sum_wide[DRIFT_W-1:0];
            end
        end
    end

    assign latency     = (a_data_reg.now - send_stamp_reg) >> 1;
    assign reply_error = a_data_reg.now - (a_data_reg.remote_stamp + latency);

    always_comb begin
        res_ping             = '0;
        res_ping.out_kind    = OUT_PING;
        res_ping.dest_x      = a_step_reg.pos.x;
        res_ping.dest_y      = a_step_reg.pos.y;
        res_ping.dest_core   = a_step_reg.pos.core;
        res_ping.route_order = ping_order;
        res_ping.payload     = ping_bit;
        res_ping.last        = 1'b1;

        res_report             = '0;
        res_report.out_kind    = OUT_REPORT;
        res_report.responses   = reply_count_upd;
        res_report.missing     = miss_count_upd;
        res_report.drift_total = drift_sum_upd;

        res_corr             = '0;
        res_corr.out_kind    = OUT_CORR;
        res_corr.dest_x      = cur_pos_reg.x;
        res_corr.dest_y      = cur_pos_reg.y;
        res_corr.dest_core   = cur_pos_reg.core;
        res_corr.route_order = sent_order_reg;
        res_corr.payload     = reply_error & ~ping_bit;
        res_corr.last        = 1'b1;

        if (!a_is_tick) begin
            res0 = res_corr;
            res1 = res_ping;
        end else if (a_step_reg.wrap) begin
            res0 = res_report;
            res1 = res_ping;
        end else begin
            res0 = res_ping;
            res1 = res_report;
        end
    end

    always_comb begin
        cur_pos_next     = cur_pos_reg;
        sent_order_next  = sent_order_reg;
        send_stamp_next  = send_stamp_reg;
        error_value_next = error_value_reg;
        reply_seen_next  = reply_seen_reg;
        reply_count_next = reply_count_reg;
        miss_count_next  = miss_count_reg;
        drift_sum_next   = drift_sum_reg;
        if (a_fire) begin
            if (!a_is_tick) begin
                error_value_next = reply_error;
                reply_seen_next  = 1'b1;
            end else begin
                cur_pos_next    = a_step_reg.pos;
                sent_order_next = ping_order;
                send_stamp_next = a_data_reg.now;
                reply_seen_next = 1'b0;
                if (a_step_reg.wrap) begin
                    reply_count_next = '0;
                    miss_count_next  = '0;
                    drift_sum_next   = '0;
                end else begin
                    reply_count_next = reply_count_upd;
                    miss_count_next  = miss_count_upd;
                    drift_sum_next   = drift_sum_upd;
                end
            end
        end
    end

    // ---------------------------------------------------------------- output queue
    always_comb begin
        q0_next    = q_reg[0];
        q1_next    = q_reg[1];
        q_cnt_next = q_cnt_reg;
        if (pop) begin
            q0_next    = q_reg[1];
            q_cnt_next = q_cnt_reg - 1'b1;
        end
        if (a_fire) begin
            if (q_cnt_next == 2'd0) begin
                q0_next = res0;
                q1_next = res1;
            end else begin
                q1_next = res0;
            end
            q_cnt_next = q_cnt_next + a_need;
        end
    end

    assign m_valid = (q_cnt_reg != 2'd0);
    assign m_data  = q_reg[0];

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg  <= 1'b1;
            clr_addr_reg    <= '0;
            la_pos_reg      <= START_POS;
            a_valid_reg     <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            cur_pos_reg     <= START_POS;
            sent_order_reg  <= '0;
            send_stamp_reg  <= '0;
            error_value_reg <= '0;
            reply_seen_reg  <= 1'b1;
            reply_count_reg <= '0;
            miss_count_reg  <= '0;
            drift_sum_reg   <= '0;
            q_cnt_reg       <= '0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(TABLE_SIZE - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept) begin
                a_valid_reg <= 1'b1;
                fwd_hit_reg <= tbl_wr_run && (cur_addr == rd_addr);
                if (s_data.kind == KIND_TICK) begin
                    la_pos_reg <= la_step.pos;
                end
            end else if (a_fire) begin
                a_valid_reg <= 1'b0;
            end
            cur_pos_reg     <= cur_pos_next;
            sent_order_reg  <= sent_order_next;
            send_stamp_reg  <= send_stamp_next;
            error_value_reg <= error_value_next;
            reply_seen_reg  <= reply_seen_next;
            reply_count_reg <= reply_count_next;
            miss_count_reg  <= miss_count_next;
            drift_sum_reg   <= drift_sum_next;
            q_cnt_reg       <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_data_reg    <= s_data;
            a_step_reg    <= la_step;
            a_rd_addr_reg <= rd_addr;
            fwd_data_reg  <= ord_inc;
        end
        q_reg[0] <= q0_next;
        q_reg[1] <= q1_next;
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for clock_sync_ping_scanner_core: random tick/reply traffic
// with handshake gaps on both sides, checked against a behavioral scan predictor.
// Depends on rtl/csps_pkg.sv and rtl/clock_sync_ping_scanner_core.sv.
module tb_top;
    import csps_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int NUM_ITEMS      = 1400;

    // Predicts the scanner's transactions and holds them until the block produces them.
    class ping_scoreboard;
        logic [X_W-1:0]     pos_x;
        logic [Y_W-1:0]     pos_y;
        logic [CORE_W-1:0]  pos_core;
        logic [ORDER_W-1:0] order_tbl [TABLE_SIZE];
        logic [ORDER_W-1:0] ping_order;
        logic [TIME_W-1:0]  ping_stamp;
        logic [TIME_W-1:0]  clk_err;
        bit                 answered;
        logic [CNT_W-1:0]   n_replies;
        logic [CNT_W-1:0]   n_missed;
        logic [DRIFT_W-1:0] drift;
        csps_out_t          expected_q[$];
        int                 fails;
        int                 reports;

        function new();
            pos_x      = '0;
            pos_y      = '0;
            pos_core   = CORE_W'(1);
            foreach (order_tbl[i]) order_tbl[i] = '0;
            ping_order = '0;
            ping_stamp = '0;
            clk_err    = '0;
            answered   = 1'b1;
            n_replies  = '0;
            n_missed   = '0;
            drift      = '0;
            fails      = 0;
            reports    = 0;
        endfunction

        function int target_index();
            return (int'(pos_x) * GRID_HEIGHT + int'(pos_y)) * (CORES + 1) + int'(pos_core);
        endfunction

        // Moves to the next target; returns 1 when the core index runs past the last core.
        function bit step_target();
            if (int'(pos_x) + 1 < GRID_WIDTH) begin
                pos_x = pos_x + 1'b1;
                return 1'b0;
            end
            pos_x = '0;
            if (int'(pos_y) + 1 < GRID_HEIGHT) begin
                pos_y = pos_y + 1'b1;
                return 1'b0;
            end
            pos_y = '0;
            if (int'(pos_core) + 1 <= CORES) begin
                pos_core = pos_core + 1'b1;
                return 1'b0;
            end
            pos_core = CORE_W'(1);
            return 1'b1;
        endfunction

        function void note_input(csps_in_t it);
            csps_out_t         r;
            logic [TIME_W-1:0] half_rtt;
            logic [TIME_W-1:0] mag;
            logic [TIME_W:0]   sum;
            bit                wrapped;
            int                idx;
            r = '0;
            if (it.kind == KIND_REPLY) begin
                half_rtt = (it.now - ping_stamp) >> 1;
                clk_err  = it.now - (it.remote_stamp + half_rtt);
                answered = 1'b1;
                r.out_kind    = OUT_CORR;
                r.dest_x      = pos_x;
                r.dest_y      = pos_y;
                r.dest_core   = pos_core;
                r.route_order = ping_order;
                r.payload     = clk_err & ~(TIME_W'(1) << PING_BIT_POS);
                r.last        = 1'b1;
                expected_q.push_back(r);
                return;
            end

            // Book the outcome of the previous ping before moving on.
            if (!answered) begin
                idx = target_index();
                order_tbl[idx] = ORDER_W'((int'(order_tbl[idx]) + 1) % DIM_ORDERS);
                if (n_missed != CNT_MAX) n_missed = n_missed + 1'b1;
            end else begin
                mag = clk_err[TIME_W-1] ? (~clk_err + 1'b1) : clk_err;
                sum = {1'b0, TIME_W'(drift)} + {1'b0, mag};
                drift = (sum > DRIFT_MAX) ? DRIFT_MAX : sum[DRIFT_W-1:0];
                if (n_replies != CNT_MAX) n_replies = n_replies + 1'b1;
            end

            wrapped = step_target();
            // The master's own position is never pinged.
            if (pos_x == '0 && pos_y == '0 && pos_core == CORE_W'(1)) begin
                if (step_target()) wrapped = 1'b1;
            end
            if (wrapped) begin
                r.out_kind    = OUT_REPORT;
                r.responses   = n_replies;
                r.missing     = n_missed;
                r.drift_total = drift;
                expected_q.push_back(r);
                reports++;
                n_replies = '0;
                n_missed  = '0;
                drift     = '0;
            end

            ping_order = order_tbl[target_index()];
            answered   = 1'b0;
            ping_stamp = it.now;
            r = '0;
            r.out_kind    = OUT_PING;
            r.dest_x      = pos_x;
            r.dest_y      = pos_y;
            r.dest_core   = pos_core;
            r.route_order = ping_order;
            r.payload     = TIME_W'(1) << PING_BIT_POS;
            r.last        = 1'b1;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
            if (act_val !== exp_val) begin
                $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
                fails++;
            end
        endfunction

        function void check_result(csps_out_t got);
            csps_out_t want;
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing expected: %h", got);
                fails++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_kind", 64'(want.out_kind), 64'(got.out_kind));
            compare_field("dest_x", 64'(want.dest_x), 64'(got.dest_x));
            compare_field("dest_y", 64'(want.dest_y), 64'(got.dest_y));
            compare_field("dest_core", 64'(want.dest_core), 64'(got.dest_core));
            compare_field("route_order", 64'(want.route_order), 64'(got.route_order));
            compare_field("payload", 64'(want.payload), 64'(got.payload));
            compare_field("responses", 64'(want.responses), 64'(got.responses));
            compare_field("missing", 64'(want.missing), 64'(got.missing));
            compare_field("drift_total", 64'(want.drift_total), 64'(got.drift_total));
            compare_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    csps_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    csps_out_t m_data;

    ping_scoreboard    sb;
    int                in_gap_max;
    int                out_stall_max;
    int                items_sent;
    int                idle_cycles;
    logic [TIME_W-1:0] last_tick_now;
    logic [TIME_W-1:0] timer_now;

    clock_sync_ping_scanner_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Any cycle that moves a transaction on either side resets the hang counter.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_item(input csps_in_t it);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] now);
        csps_in_t it;
        it.kind         = KIND_TICK;
        it.remote_stamp = $urandom();
        it.now          = now;
        last_tick_now   = now;
        push_item(it);
    endtask

    task automatic send_reply(input logic [TIME_W-1:0] remote, input logic [TIME_W-1:0] now);
        csps_in_t it;
        it.kind         = KIND_REPLY;
        it.remote_stamp = remote;
        it.now          = now;
        push_item(it);
    endtask

    // A reply as a real remote node would send it: plausible round trip, small offset.
    task automatic send_clean_reply();
        logic [TIME_W-1:0] rtt;
        logic [TIME_W-1:0] rx_now;
        int                offset;
        rtt    = $urandom_range(0, 4000);
        offset = int'($urandom_range(0, 1000)) - 500;
        rx_now = last_tick_now + rtt;
        send_reply(rx_now - (rtt >> 1) - TIME_W'(offset), rx_now);
    endtask

    // Result side: random stalls, with occasional stretches of none.
    initial begin
        int stall;
        int taken;
        m_ready       = 1'b0;
        out_stall_max = 12;
        taken         = 0;
        forever begin
            if (taken % 64 == 0) out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            stall = $urandom_range(0, out_stall_max);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_data);
            taken++;
        end
    end

    initial begin
        int sel;
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        idle_cycles   = 0;
        items_sent    = 0;
        in_gap_max    = 12;
        last_tick_now = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reply before any ping, field extremes, error of exactly -2^31,
        // first tick after reset, drift saturation and back-to-back misses.
        send_reply('0, '0);
        send_reply('1, '1);
        send_tick('0);
        send_reply(32'h8000_0032, 32'd100);  // 50 - remote = 0x8000_0000
        send_tick(32'd200);
        send_tick('1);
        send_tick('0);
        send_reply('0, '1);
        send_reply('1, '0);
        send_tick(32'h5555_5555);
        send_clean_reply();
        send_tick(32'hAAAA_AAAA);
        send_clean_reply();
        send_clean_reply();
        send_tick(32'h0000_FFFF);

        // Random: mostly ping/reply pairs on a running timer, plus misses, duplicate
        // replies and noise, until about NUM_ITEMS transactions have been sent.
        timer_now = $urandom();
        while (items_sent < NUM_ITEMS) begin
            if (items_sent % 150 < 2) in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            sel = $urandom_range(0, 99);
            timer_now = timer_now + $urandom_range(1, 5000);
            if (sel < 70) begin
                send_tick(timer_now);
                if ($urandom_range(0, 99) < 60) send_clean_reply();
            end else if (sel < 85) begin
                send_tick(timer_now);
            end else if (sel < 93) begin
                send_clean_reply();
            end else if (sb.reports == 0) begin
                send_reply($urandom(), $urandom());
            end else begin
                // Keep the later scans free of wild errors so their drift stays unsaturated.
                send_tick($urandom());
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.fails == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
